>>> hw/rtl/binomial_coefficient_unit_top_defines.svh
// Assertion macros for the binomial coefficient unit checker.
// Used only by bcu_chk; no other dependencies.
`ifndef BINOMIAL_COEFFICIENT_UNIT_TOP_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_UNIT_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BCU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bcu assertion failed");

// next-cycle implication, disabled during reset
`define BCU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bcu assertion failed");

`endif

>>> hw/rtl/bcu_pkg.sv
// Shared widths, constants and controller/datapath interface types.
// No dependencies.
package bcu_pkg;

    localparam int ARG_W      = 32;
    localparam int RES_W      = 64;
    localparam int B_W        = RES_W - 1;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = RES_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int TDATA_IN_W = 2 * ARG_W;

    localparam logic [RES_W-1:0] RES_ALL_ONES = {RES_W{1'b1}};

    typedef struct packed {
        logic load_in;
        logic setup;
        logic mul_lo;
        logic mul_hi;
        logic check;
        logic div_step;
        logic advance;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic special;
        logic ovf;
        logic div_last;
        logic i_is_k;
        logic out_free;
    } t_sts;

endpackage

>>> hw/rtl/binomial_coefficient_unit_top.sv
// Binomial coefficient unit top level: C(n,k) as 64 bits, all ones on overflow.
// Depends on bcu_pkg, bcu_ctrl, bcu_dp.
//
//   port group   dir   contents
//   s_axis       in    tdata = {k_value[31:0], n_value[31:0]}
//   m_axis       out   tdata = coefficient[63:0]
//
// One item at a time. Trivial cases (k = 0, k = n, k > n, folded k = 1) go from setup straight
// to the output register; otherwise one full iteration runs for each i from 1 up to folded k,
// and an overflowing iteration stops after its overflow check.
// Each iteration: two-pass 32x32 multiply, check, radix-16 divide, advance.
// Synchronous active-low reset clears the sequencer and output valid.
// A stalled m_axis holds a finished result in the sequencer and keeps s_axis_tready low.
module binomial_coefficient_unit_top
    import bcu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_IN_W-1:0] s_axis_tdata,   // n_value[31:0], k_value[63:32]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [RES_W-1:0]      m_axis_tdata    // coefficient[63:0]
);

    t_cmd cmd;
    t_sts sts;

    bcu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bcu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_tdata     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

>>> hw/rtl/bcu_dp.sv
// Datapath: argument registers, split multiplier, radix-16 divider, output register.
// Depends on bcu_pkg.
module bcu_dp
    import bcu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [TDATA_IN_W-1:0] i_tdata,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [RES_W-1:0]      o_out_data
);

    logic [ARG_W-1:0]        r_n, r_k, r_kf, r_fac, r_i, r_rem;
    logic [B_W-1:0]          r_b;
    logic [2*ARG_W-1:0]      r_plo;
    logic [2*ARG_W-1:0]      r_phi;
    logic [RES_W-1:0]        r_dvd, r_res, r_out_data;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic                    r_out_valid, n_out_valid;

    logic [ARG_W-1:0]        nmk, kf;
    logic                    k_edge, k_gt, special;
    logic [RES_W-1:0]        spec_val;
    logic [B_W+2*ARG_W-1:0]  prod;
    logic [ARG_W-1:0]        div_rem;
    logic [RES_W-1:0]        div_dvd;

    assign nmk     = r_n - r_k;
    assign k_gt    = r_k > r_n;
    assign k_edge  = (r_k == '0) || (r_k == r_n);
    assign kf      = (r_k > nmk) ? nmk : r_k;
    assign special = k_edge || k_gt || (kf == ARG_W'(1));

    always_comb begin
        if (k_edge) begin
            spec_val = RES_W'(1);
        end else if (k_gt) begin
            spec_val = '0;
        end else begin
            spec_val = RES_W'(r_n);
        end
    end

    assign prod = (B_W+2*ARG_W)'({r_phi, {ARG_W{1'b0}}}) + (B_W+2*ARG_W)'(r_plo);

    always_comb begin
        logic [ARG_W:0] t;
        div_rem = r_rem;
        div_dvd = r_dvd;
        for (int j = 0; j < DIV_BITS; j++) begin
            t       = {div_rem, div_dvd[RES_W-1]};
            div_dvd = {div_dvd[RES_W-2:0], 1'b0};
            if (t >= {1'b0, r_i}) begin
                t          = t - {1'b0, r_i};
                div_dvd[0] = 1'b1;
            end
            div_rem = t[ARG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_n <= i_tdata[ARG_W-1:0];
            r_k <= i_tdata[2*ARG_W-1:ARG_W];
        end
        if (i_cmd.setup) begin
            r_res <= spec_val;
            r_kf  <= kf;
            r_fac <= r_n - kf + ARG_W'(1);
            r_i   <= ARG_W'(1);
            r_b   <= B_W'(1);
        end
        if (i_cmd.mul_lo) begin
            r_plo <= (2*ARG_W)'(r_b[ARG_W-1:0]) * (2*ARG_W)'(r_fac);
        end
        if (i_cmd.mul_hi) begin
            r_phi <= (2*ARG_W)'(r_b[B_W-1:ARG_W]) * (2*ARG_W)'(r_fac);
        end
        if (i_cmd.check) begin
            r_res <= RES_ALL_ONES;
            r_dvd <= {1'b0, prod[B_W-1:0]};
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= div_dvd;
            r_rem <= div_rem;
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.advance) begin
            r_b   <= r_dvd[B_W-1:0];
            r_res <= {1'b0, r_dvd[B_W-1:0]};
            r_i   <= r_i + ARG_W'(1);
            r_fac <= r_fac + ARG_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_res;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_sts.special  = special;
    assign o_sts.ovf      = |prod[B_W+2*ARG_W-1:B_W];
    assign o_sts.div_last = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_sts.i_is_k   = (r_i == r_kf);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> hw/rtl/bcu_ctrl.sv
// Controller: one-hot sequencer over setup, multiply, overflow check, divide, advance.
// Depends on bcu_pkg.
module bcu_ctrl
    import bcu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SETUP  = 8'b0000_0010,
        S_MUL_LO = 8'b0000_0100,
        S_MUL_HI = 8'b0000_1000,
        S_CHECK  = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_NEXT   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_sts.special ? S_DONE : S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.ovf ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.advance = 1'b1;
                n_state       = i_sts.i_is_k ? S_DONE : S_MUL_LO;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

>>> hw/rtl/bcu_chk.sv
// Port-level checker for the binomial coefficient unit, bound to the top level.
// Depends on bcu_pkg and binomial_coefficient_unit_top_defines.svh.
`include "binomial_coefficient_unit_top_defines.svh"

module bcu_chk
    import bcu_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [RES_W-1:0]      m_axis_tdata
);

    `BCU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `BCU_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `BCU_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `BCU_ASSERT_IMPL(a_result_frees_in, $rose(m_axis_tvalid), s_axis_tready && $past(!s_axis_tready))

endmodule

bind binomial_coefficient_unit_top bcu_chk u_bcu_chk (.*);
